FILE: hdl/tlg_pkg.sv
// tremolo lfo gain: shared types and constants
// register codes, q16 constants, lfo shape codes, control and status structs
// no dependencies
`default_nettype none

package tlg_pkg;

   // configuration register indexes
   localparam logic [2:0] REG_PHASE_STEP   = 3'd0;
   localparam logic [2:0] REG_MOD_DEPTH    = 3'd1;
   localparam logic [2:0] REG_LFO_SHAPE    = 3'd2;
   localparam logic [2:0] REG_SMOOTH_COEFF = 3'd3;
   localparam logic [2:0] REG_CHANNELS     = 3'd4;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 24;

   // lfo shape codes, anything else is the smoothed square
   localparam logic [1:0] SHAPE_SINE     = 2'd0;
   localparam logic [1:0] SHAPE_TRIANGLE = 2'd1;

   localparam logic [16:0] ONE_Q16      = 17'd65536;
   localparam logic [16:0] BYPASS_DEPTH = 17'd66;
   localparam logic [16:0] HALF_Q16     = 17'd32768;

   // pi/2 in q30, used to build the sine table
   localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

   // reset values
   localparam logic [23:0] PHASE_STEP_RESET   = 24'd44739;
   localparam logic [16:0] MOD_DEPTH_RESET    = 17'd45875;
   localparam logic [1:0]  LFO_SHAPE_RESET    = 2'd0;
   localparam logic [16:0] SMOOTH_COEFF_RESET = 17'd557;
   localparam logic [1:0]  CHANNELS_RESET     = 2'd2;

   localparam logic [31:0] LEFT_PHASE_RESET  = 32'h0000_0000;
   localparam logic [31:0] RIGHT_PHASE_RESET = 32'h4000_0000;

   // frame queue between front and back
   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_LVL_W = $clog2(QUEUE_DEPTH + 1);

   typedef struct packed {
      logic [23:0] phase_step;
      logic [16:0] mod_depth;
      logic [1:0]  lfo_shape;
      logic [16:0] smooth_coeff;
      logic [1:0]  channels_used;
   } cfg_type;

   typedef struct packed {
      logic                   not_empty;
      logic [QUEUE_LVL_W-1:0] level;
   } front_sts_type;

   typedef struct packed {
      logic pop;
      logic load_out;
   } back_ctl_type;

endpackage

`default_nettype wire

FILE: hdl/tlg_front.sv
// tremolo lfo gain: front end, takes frames, decides how many channels to modulate
// and holds them in a short queue for the back end; uses tlg_pkg
`default_nettype none

module tlg_front
   import tlg_pkg::*;
#(
   parameter int SAMPLE_BITS = 24,
   parameter int CHANNELS    = 2
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire cfg_type                       cfg,
   input  wire logic                          req_tvalid,
   output logic                               req_tready,
   input  wire logic signed [SAMPLE_BITS-1:0] req_left,
   input  wire logic signed [SAMPLE_BITS-1:0] req_right,
   input  wire back_ctl_type                  back_ctl,
   output logic signed [SAMPLE_BITS-1:0]      q_left,
   output logic signed [SAMPLE_BITS-1:0]      q_right,
   output logic [1:0]                         q_count,
   output front_sts_type                      sts
);

   logic signed [SAMPLE_BITS-1:0] left_mem_ff  [QUEUE_DEPTH];
   logic signed [SAMPLE_BITS-1:0] right_mem_ff [QUEUE_DEPTH];
   logic [1:0]                    count_mem_ff [QUEUE_DEPTH];

   logic [QUEUE_PTR_W-1:0] wr_ptr_ff;
   logic [QUEUE_PTR_W-1:0] rd_ptr_ff;
   logic [QUEUE_LVL_W-1:0] level_ff;
   logic [QUEUE_LVL_W-1:0] level_in;

   logic       push;
   logic       bypass;
   logic [1:0] chan_lim;
   logic [1:0] count_in;

   // channels modulated: min(channels_used, CHANNELS), none when depth is tiny
   always_comb begin
      bypass   = cfg.mod_depth < BYPASS_DEPTH;
      chan_lim = (cfg.channels_used > 2'(CHANNELS)) ? 2'(CHANNELS) : cfg.channels_used;
      count_in = bypass ? 2'd0 : chan_lim;
   end

   assign req_tready = level_ff != QUEUE_LVL_W'(QUEUE_DEPTH);
   assign push       = req_tvalid && req_tready;

   always_comb begin
      level_in = level_ff;
      if (push && !back_ctl.pop) begin
         level_in = level_ff + 1'b1;
      end else if (!push && back_ctl.pop) begin
         level_in = level_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         level_ff <= level_in;
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (back_ctl.pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         left_mem_ff[wr_ptr_ff]  <= req_left;
         right_mem_ff[wr_ptr_ff] <= req_right;
         count_mem_ff[wr_ptr_ff] <= count_in;
      end
   end

   assign q_left        = left_mem_ff[rd_ptr_ff];
   assign q_right       = right_mem_ff[rd_ptr_ff];
   assign q_count       = count_mem_ff[rd_ptr_ff];
   assign sts.not_empty = level_ff != '0;
   assign sts.level     = level_ff;

endmodule

`default_nettype wire

FILE: hdl/tlg_back.sv
// tremolo lfo gain: back end sequencer, per channel lfo lookup, gain and scaling
// holds the lfo phase and square level state and the sine rom; uses tlg_pkg
`default_nettype none

module tlg_back
   import tlg_pkg::*;
#(
   parameter int SAMPLE_BITS     = 24,
   parameter int SINE_TABLE_BITS = 10,
   parameter int CHANNELS        = 2
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire cfg_type                       cfg,
   input  wire front_sts_type                 front_sts,
   input  wire logic signed [SAMPLE_BITS-1:0] q_left,
   input  wire logic signed [SAMPLE_BITS-1:0] q_right,
   input  wire logic [1:0]                    q_count,
   output back_ctl_type                       ctl,
   output logic                               rsp_tvalid,
   input  wire logic                          rsp_tready,
   output logic signed [SAMPLE_BITS-1:0]      rsp_left,
   output logic signed [SAMPLE_BITS-1:0]      rsp_right
);

   localparam int TAB_N  = 1 << SINE_TABLE_BITS;
   localparam int ADDR_W = SINE_TABLE_BITS + 1;
   localparam int PROD_W = SAMPLE_BITS + 18;

   typedef logic [15:0] sine_rom_type [TAB_N+1];

   // quarter sine in q15 by integer taylor series
   function automatic sine_rom_type build_sine();
      sine_rom_type tab;
      logic [63:0]  x;
      logic [63:0]  x2;
      logic [63:0]  term;
      logic [63:0]  sum;
      logic [63:0]  t;
      int           i;
      int           k;
      for (i = 0; i <= TAB_N; i++) begin
         x    = (64'(i) * HALF_PI_Q30) >> SINE_TABLE_BITS;
         x2   = (x * x) >> 30;
         term = x;
         sum  = x;
         for (k = 1; k <= 7; k++) begin
            t = (term * x2) >> 30;
            case (k)
               1: term = t / 64'd6;
               2: term = t / 64'd20;
               3: term = t / 64'd42;
               4: term = t / 64'd72;
               5: term = t / 64'd110;
               6: term = t / 64'd156;
               default: term = t / 64'd210;
            endcase
            if (k % 2 == 1) begin
               sum = sum - term;
            end else begin
               sum = sum + term;
            end
         end
         sum    = (sum + 64'd16384) >> 15;
         tab[i] = (sum > 64'd32768) ? 16'd32768 : sum[15:0];
      end
      return tab;
   endfunction

   localparam sine_rom_type SINE_ROM = build_sine();

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_ADDR,
      ST_SHAPE,
      ST_LEVEL,
      ST_SCALE,
      ST_GAIN,
      ST_PROD,
      ST_NEXT,
      ST_DONE
   } state_type;

   state_type state_ff;

   logic [31:0] phase_ff [CHANNELS];
   logic [16:0] level_ff [CHANNELS];

   logic signed [SAMPLE_BITS-1:0] smp_ff [2];
   logic [1:0]                    count_ff;
   logic                          ch_ff;
   logic [15:0]                   rom_q_ff;
   logic [16:0]                   lfo_ff;
   logic [33:0]                   sq_prod_ff;
   logic                          sq_up_ff;
   logic [33:0]                   dl_ff;
   logic [16:0]                   gain_ff;
   logic signed [PROD_W-1:0]      prod_ff;
   logic                          rsp_valid_ff;
   logic signed [SAMPLE_BITS-1:0] rsp_left_ff;
   logic signed [SAMPLE_BITS-1:0] rsp_right_ff;

   logic [31:0]                cur_phase;
   logic [16:0]                cur_level;
   logic [SINE_TABLE_BITS-1:0] tab_idx;
   logic [ADDR_W-1:0]          rom_addr;
   logic [16:0]                depth_sat;
   logic [16:0]                coeff_sat;
   logic                       is_square;
   logic [16:0]                sine_lfo;
   logic [32:0]                tri_dist;
   logic [16:0]                sq_target;
   logic                       sq_up;
   logic [16:0]                sq_diff;
   logic [17:0]                level_in;
   logic [17:0]                gain_in;

   assign cur_phase = phase_ff[ch_ff];
   assign cur_level = level_ff[ch_ff];
   assign depth_sat = (cfg.mod_depth > ONE_Q16) ? ONE_Q16 : cfg.mod_depth;
   assign coeff_sat = (cfg.smooth_coeff > ONE_Q16) ? ONE_Q16 : cfg.smooth_coeff;
   assign is_square = !(cfg.lfo_shape inside {SHAPE_SINE, SHAPE_TRIANGLE});

   // odd quadrants read the table backwards
   assign tab_idx  = cur_phase[29 -: SINE_TABLE_BITS];
   assign rom_addr = cur_phase[30] ? (ADDR_W'(TAB_N) - {1'b0, tab_idx}) : {1'b0, tab_idx};

   always_ff @(posedge clock) begin
      rom_q_ff <= SINE_ROM[rom_addr];
   end

   always_comb begin
      sine_lfo  = cur_phase[31] ? (HALF_Q16 - {1'b0, rom_q_ff})
                                : (HALF_Q16 + {1'b0, rom_q_ff});
      tri_dist  = cur_phase[31] ? (33'h1_0000_0000 - {1'b0, cur_phase}) : {1'b0, cur_phase};
      sq_target = cur_phase[31] ? 17'd0 : ONE_Q16;
      sq_up     = sq_target >= cur_level;
      sq_diff   = sq_up ? (sq_target - cur_level) : (cur_level - sq_target);
      if (sq_up_ff) begin
         level_in = {1'b0, cur_level} + sq_prod_ff[33:16];
      end else begin
         level_in = {1'b0, cur_level} - sq_prod_ff[33:16];
      end
      if (level_in > {1'b0, ONE_Q16}) begin
         level_in = {1'b0, ONE_Q16};
      end
      gain_in = {1'b0, ONE_Q16 - depth_sat} + dl_ff[33:16];
   end

   assign ctl.pop      = (state_ff == ST_IDLE) && front_sts.not_empty;
   assign ctl.load_out = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         phase_ff[0]  <= LEFT_PHASE_RESET;
         level_ff[0]  <= '0;
         if (CHANNELS > 1) begin
            phase_ff[CHANNELS-1] <= RIGHT_PHASE_RESET;
            level_ff[CHANNELS-1] <= '0;
         end
         ch_ff        <= 1'b0;
      end else begin
         if (ctl.load_out) begin
            rsp_valid_ff <= 1'b1;
            rsp_left_ff  <= smp_ff[0];
            rsp_right_ff <= smp_ff[1];
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (ctl.pop) begin
                  smp_ff[0] <= q_left;
                  smp_ff[1] <= q_right;
                  count_ff  <= q_count;
                  ch_ff     <= 1'b0;
                  state_ff  <= (q_count == 2'd0) ? ST_DONE : ST_ADDR;
               end
            end
            ST_ADDR: begin
               state_ff <= ST_SHAPE;
            end
            ST_SHAPE: begin
               case (cfg.lfo_shape)
                  SHAPE_SINE:     lfo_ff <= sine_lfo;
                  SHAPE_TRIANGLE: lfo_ff <= tri_dist[31:15];
                  default: begin
                     sq_prod_ff <= coeff_sat * sq_diff;
                     sq_up_ff   <= sq_up;
                  end
               endcase
               state_ff <= ST_LEVEL;
            end
            ST_LEVEL: begin
               if (is_square) begin
                  level_ff[ch_ff] <= level_in[16:0];
                  lfo_ff          <= level_in[16:0];
               end
               state_ff <= ST_SCALE;
            end
            ST_SCALE: begin
               dl_ff    <= depth_sat * lfo_ff;
               state_ff <= ST_GAIN;
            end
            ST_GAIN: begin
               gain_ff  <= gain_in[16:0];
               state_ff <= ST_PROD;
            end
            ST_PROD: begin
               prod_ff  <= smp_ff[ch_ff] * $signed({1'b0, gain_ff});
               state_ff <= ST_NEXT;
            end
            ST_NEXT: begin
               // arithmetic shift rounds toward minus infinity
               smp_ff[ch_ff]   <= prod_ff[SAMPLE_BITS+15:16];
               phase_ff[ch_ff] <= cur_phase + {8'd0, cfg.phase_step};
               if ({1'b0, ch_ff} + 2'd1 < count_ff) begin
                  ch_ff    <= ch_ff + 1'b1;
                  state_ff <= ST_ADDR;
               end else begin
                  state_ff <= ST_DONE;
               end
            end
            ST_DONE: begin
               if (ctl.load_out) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_left   = rsp_left_ff;
   assign rsp_right  = rsp_right_ff;

endmodule

`default_nettype wire

FILE: hdl/tremolo_lfo_gain_top.sv
// tremolo lfo gain: top level, configuration registers and stream ports
// instantiates tlg_front and tlg_back; uses tlg_pkg
`default_nettype none

// Stereo tremolo. Each beat on req carries one frame (left and right sample);
// each frame gives exactly one beat on rsp, in order. Each modulated channel
// is scaled by a q16 gain built from an lfo (sine, triangle or smoothed
// square) whose phase advances by phase_step per frame. The front end queues
// up to two frames, so input keeps flowing while the back end works. The back
// end sequencer pops a frame, walks the modulated channels one at a time
// through the sine rom read and a chain of three registered multiplies, in
// the states addr, shape, level, scale, gain, prod and next per channel, and
// then loads the output; in bypass (depth below 66) it goes from pop straight
// to the load. The sine table is a constant rom built at elaboration, so there
// is no start-up pass. Write configuration only while no frame is in flight.
module tremolo_lfo_gain_top
   import tlg_pkg::*;
#(
   parameter int SAMPLE_BITS     = 24,
   parameter int SINE_TABLE_BITS = 10,
   parameter int CHANNELS        = 2
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   // req beat: left_sample, right_sample, zero pad
   input  wire logic [((2*SAMPLE_BITS+7)/8)*8-1:0] req_tdata,
   input  wire logic                   req_tvalid,
   output logic                        req_tready,
   // rsp beat: left_out, right_out, zero pad
   output logic [((2*SAMPLE_BITS+7)/8)*8-1:0]      rsp_tdata,
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   input  wire logic                   csr_wen,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_wdata
);

   localparam int DATA_W = ((2 * SAMPLE_BITS + 7) / 8) * 8;

   cfg_type       cfg_ff;
   front_sts_type front_sts;
   back_ctl_type  back_ctl;

   logic signed [SAMPLE_BITS-1:0] q_left;
   logic signed [SAMPLE_BITS-1:0] q_right;
   logic [1:0]                    q_count;
   logic signed [SAMPLE_BITS-1:0] rsp_left;
   logic signed [SAMPLE_BITS-1:0] rsp_right;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.phase_step    <= PHASE_STEP_RESET;
         cfg_ff.mod_depth     <= MOD_DEPTH_RESET;
         cfg_ff.lfo_shape     <= LFO_SHAPE_RESET;
         cfg_ff.smooth_coeff  <= SMOOTH_COEFF_RESET;
         cfg_ff.channels_used <= CHANNELS_RESET;
      end else if (csr_wen) begin
         case (csr_index)
            REG_PHASE_STEP:   cfg_ff.phase_step    <= csr_wdata[23:0];
            REG_MOD_DEPTH:    cfg_ff.mod_depth     <= csr_wdata[16:0];
            REG_LFO_SHAPE:    cfg_ff.lfo_shape     <= csr_wdata[1:0];
            REG_SMOOTH_COEFF: cfg_ff.smooth_coeff  <= csr_wdata[16:0];
            REG_CHANNELS:     cfg_ff.channels_used <= csr_wdata[1:0];
            default: begin
            end
         endcase
      end
   end

   tlg_front #(
      .SAMPLE_BITS (SAMPLE_BITS),
      .CHANNELS    (CHANNELS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_left   ($signed(req_tdata[SAMPLE_BITS-1:0])),
      .req_right  ($signed(req_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS])),
      .back_ctl   (back_ctl),
      .q_left     (q_left),
      .q_right    (q_right),
      .q_count    (q_count),
      .sts        (front_sts)
   );

   tlg_back #(
      .SAMPLE_BITS     (SAMPLE_BITS),
      .SINE_TABLE_BITS (SINE_TABLE_BITS),
      .CHANNELS        (CHANNELS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .front_sts  (front_sts),
      .q_left     (q_left),
      .q_right    (q_right),
      .q_count    (q_count),
      .ctl        (back_ctl),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_left   (rsp_left),
      .rsp_right  (rsp_right)
   );

   assign rsp_tdata = DATA_W'({rsp_right, rsp_left});

   // queue fill never passes its depth
   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      front_sts.level <= QUEUE_LVL_W'(QUEUE_DEPTH))
      else $error("frame queue overfilled");

   // a beat taken with no pop grows the queue by one
   a_queue_grow: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && !back_ctl.pop)
         |=> (front_sts.level == $past(front_sts.level) + 1'b1))
      else $error("frame queue lost a beat");

   // rsp valid only rises after the back end loads a finished frame
   a_rsp_from_load: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(back_ctl.load_out))
      else $error("rsp beat without a finished frame");

   // the back end only pops a queue holding a frame
   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      back_ctl.pop |-> (front_sts.level != '0))
      else $error("pop from empty queue");

endmodule

`default_nettype wire

FILE: verif/tb.sv
// testbench for tremolo_lfo_gain_top: random and directed stereo frames, checked beat by beat
// scoreboard class predicts each frame from its own copy of lfo state and registers
// depends on tlg_pkg and the rtl top level only
`timescale 1ns / 1ps

module tb
   import tlg_pkg::*;
;
   localparam int SAMPLE_W         = 24;
   localparam int DATA_W           = ((2*SAMPLE_W+7)/8)*8;
   localparam int RESET_CYCLES     = 12;
   localparam int DRAIN_CYCLES     = 32;
   localparam int STALL_LIMIT      = 4000;
   localparam int BLOCKS_PER_MODE  = 8;
   localparam int FRAMES_PER_BLOCK = 50;

   localparam logic [1:0] SHAPE_SQUARE     = 2'd2;
   localparam logic [1:0] SHAPE_SQUARE_ALT = 2'd3;
   localparam logic [2:0] REG_UNUSED_FIRST = 3'd5;
   localparam logic [2:0] REG_UNUSED_LAST  = 3'd7;

   class frame_scoreboard;
      localparam int ROM_BITS = 10;
      localparam int ROM_N    = 1 << ROM_BITS;
      localparam int NCHAN    = 2;

      typedef struct {
         logic [23:0] left;
         logic [23:0] right;
      } frame_type;

      frame_type   expected_frames[$];
      int unsigned sine_rom[0:ROM_N];
      cfg_type     cfg;
      logic [31:0] lfo_phase[2];
      logic [16:0] square_level[2];
      int          errors;
      int          frames_checked;

      function new();
         longint unsigned x, x2, term, acc;
         // quarter-wave sine in q15 by integer taylor series
         for (int i = 0; i <= ROM_N; i++) begin
            x = (longint'(i) * HALF_PI_Q30) >> ROM_BITS;
            x2 = (x * x) >> 30;
            term = x;
            acc = x;
            for (int k = 1; k <= 7; k++) begin
               term = ((term * x2) >> 30) / longint'((2*k) * (2*k + 1));
               if (k % 2 == 1) acc -= term;
               else acc += term;
            end
            acc = (acc + 16384) >> 15;
            sine_rom[i] = (acc > 32768) ? 32768 : int'(acc);
         end
         errors = 0;
         frames_checked = 0;
      endfunction

      function void reset_state();
         cfg.phase_step    = PHASE_STEP_RESET;
         cfg.mod_depth     = MOD_DEPTH_RESET;
         cfg.lfo_shape     = LFO_SHAPE_RESET;
         cfg.smooth_coeff  = SMOOTH_COEFF_RESET;
         cfg.channels_used = CHANNELS_RESET;
         lfo_phase[0]      = LEFT_PHASE_RESET;
         lfo_phase[1]      = RIGHT_PHASE_RESET;
         square_level[0]   = '0;
         square_level[1]   = '0;
         expected_frames.delete();
      endfunction

      function void write_reg(logic [2:0] idx, logic [23:0] val);
         case (idx)
            REG_PHASE_STEP:   cfg.phase_step    = val;
            REG_MOD_DEPTH:    cfg.mod_depth     = val[16:0];
            REG_LFO_SHAPE:    cfg.lfo_shape     = val[1:0];
            REG_SMOOTH_COEFF: cfg.smooth_coeff  = val[16:0];
            REG_CHANNELS:     cfg.channels_used = val[1:0];
            default: ;
         endcase
      endfunction

      // lfo value in q16, 0..65536; the square shape also updates its filter
      function longint unsigned lfo_level(int ch);
         logic [31:0]     p;
         longint unsigned idx, s, d, target, c, lv;
         p = lfo_phase[ch];
         if (cfg.lfo_shape == SHAPE_SINE) begin
            idx = (p >> (30 - ROM_BITS)) & (ROM_N - 1);
            s = p[30] ? sine_rom[ROM_N - idx] : sine_rom[idx];
            return p[31] ? 32768 - s : 32768 + s;
         end
         if (cfg.lfo_shape == SHAPE_TRIANGLE) begin
            d = p[31] ? 64'h1_0000_0000 - p : p;
            return d >> 15;
         end
         target = p[31] ? 0 : ONE_Q16;
         c = (cfg.smooth_coeff > ONE_Q16) ? ONE_Q16 : cfg.smooth_coeff;
         lv = square_level[ch];
         if (target >= lv) lv += (c * (target - lv)) >> 16;
         else lv -= (c * (lv - target)) >> 16;
         if (lv > ONE_Q16) lv = ONE_Q16;
         square_level[ch] = lv[16:0];
         return lv;
      endfunction

      function logic [23:0] scale_sample(int ch, logic [23:0] s, longint unsigned depth);
         longint unsigned lfo, gain;
         longint          prod, r;
         lfo = lfo_level(ch);
         gain = (ONE_Q16 - depth) + ((depth * lfo) >> 16);
         prod = longint'(signed'(s)) * longint'(gain);
         r = prod >>> 16;
         lfo_phase[ch] = lfo_phase[ch] + 32'(cfg.phase_step);
         return r[23:0];
      endfunction

      function void note_frame(logic [DATA_W-1:0] data);
         frame_type       f;
         longint unsigned depth;
         int              nmod;
         f.left = data[23:0];
         f.right = data[47:24];
         depth = (cfg.mod_depth > ONE_Q16) ? ONE_Q16 : cfg.mod_depth;
         nmod = (cfg.channels_used > NCHAN) ? NCHAN : cfg.channels_used;
         if (depth >= BYPASS_DEPTH) begin
            if (nmod >= 1) f.left = scale_sample(0, f.left, depth);
            if (nmod >= 2) f.right = scale_sample(1, f.right, depth);
         end
         expected_frames.push_back(f);
      endfunction

      function void flag(string what, logic [23:0] want, logic [23:0] got);
         errors++;
         if (errors <= 10)
            $display("mismatch at frame %0d, %s: expected %h, got %h",
                     frames_checked, what, want, got);
      endfunction

      function void check_frame(logic [DATA_W-1:0] data);
         frame_type want;
         if (expected_frames.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected rsp beat %h with no frame pending", data);
            return;
         end
         want = expected_frames.pop_front();
         if (data[23:0] !== want.left) flag("left_out", want.left, data[23:0]);
         if (data[47:24] !== want.right) flag("right_out", want.right, data[47:24]);
         frames_checked++;
      endfunction
   endclass

   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic [DATA_W-1:0]      req_tdata  = '0;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [DATA_W-1:0]      rsp_tdata;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic                   csr_wen    = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index  = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata  = '0;

   frame_scoreboard sb;
   int unsigned     send_idle_pct = 28;
   int unsigned     recv_idle_pct = 50;
   int              stall_cycles = 0;
   int              settings_applied = 0;

   tremolo_lfo_gain_top u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .csr_wen    (csr_wen),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (reset) rsp_tready <= 1'b0;
      else rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
   end

   // monitor: sample handshakes as they stood at the edge
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) sb.note_frame(req_tdata);
         if (rsp_tvalid && rsp_tready) sb.check_frame(rsp_tdata);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_wen)
         stall_cycles <= 0;
      else
         stall_cycles <= stall_cycles + 1;
   end

   initial begin
      @(posedge clock);
      while (stall_cycles < STALL_LIMIT) @(posedge clock);
      $display("no beat for %0d cycles, %0d frames still pending",
               STALL_LIMIT, sb.expected_frames.size());
      $display("** tremolo_lfo_gain_top: FAILED **");
      $finish;
   end

   task automatic send_frame(logic [23:0] left, logic [23:0] right);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {right, left};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   // hold off input until every pending frame has come back
   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (sb.expected_frames.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic put_reg(logic [2:0] idx, logic [23:0] val);
      csr_index <= idx;
      csr_wdata <= val;
      sb.write_reg(idx, val);
      @(posedge clock);
   endtask

   // narrow registers get junk in the unused upper data bits
   task automatic apply_settings(logic [23:0] step, logic [16:0] depth, logic [1:0] shape,
                                 logic [16:0] coeff, logic [1:0] chans, bit stray);
      drain();
      csr_wen <= 1'b1;
      put_reg(REG_PHASE_STEP, step);
      put_reg(REG_MOD_DEPTH, {7'($urandom), depth});
      put_reg(REG_LFO_SHAPE, {22'($urandom), shape});
      put_reg(REG_SMOOTH_COEFF, {7'($urandom), coeff});
      put_reg(REG_CHANNELS, {22'($urandom), chans});
      if (stray) put_reg(3'($urandom_range(REG_UNUSED_LAST, REG_UNUSED_FIRST)), 24'($urandom));
      csr_wen <= 1'b0;
      settings_applied++;
   endtask

   task automatic apply_random_settings();
      logic [23:0] step;
      logic [16:0] depth, coeff;
      logic [1:0]  chans;
      case ($urandom_range(3))
         0: step = $urandom_range(1) ? 24'hFFFFFF : 24'h0;
         1: step = 24'($urandom);
         default: step = 24'($urandom_range(20'hFFFFF));
      endcase
      case ($urandom_range(7))
         0: depth = 17'($urandom_range(65));
         1: depth = 17'($urandom_range(17'h1FFFF, 65536));
         default: depth = 17'($urandom_range(65536, 66));
      endcase
      coeff = $urandom_range(2) == 0 ? 17'($urandom) : 17'($urandom_range(4000));
      chans = $urandom_range(7) < 5 ? 2'd2 : 2'($urandom_range(3));
      apply_settings(step, depth, 2'($urandom_range(3)), coeff, chans, $urandom_range(3) == 0);
   endtask

   function automatic logic [23:0] rand_sample();
      case ($urandom_range(9))
         0: return 24'h7FFFFF;
         1: return 24'h800000;
         2: return 24'($urandom_range(4)) - 24'd2;
         default: return 24'($urandom);
      endcase
   endfunction

   initial begin
      sb = new();
      sb.reset_state();
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // reset register values, sine shape
      send_frame(24'h000000, 24'h000000);
      send_frame(24'h7FFFFF, 24'h800000);
      send_frame(24'h800000, 24'h7FFFFF);
      send_frame(24'hFFFFFF, 24'h000001);
      send_frame(24'h555555, 24'hAAAAAA);
      // full depth triangle, largest step
      apply_settings(24'hFFFFFF, ONE_Q16, SHAPE_TRIANGLE, SMOOTH_COEFF_RESET, 2'd2, 1'b0);
      send_frame(24'h7FFFFF, 24'h800000);
      send_frame(24'h800000, 24'h7FFFFF);
      send_frame(rand_sample(), rand_sample());
      // depth and coefficient both above one saturate
      apply_settings(24'h100000, 17'h1FFFF, SHAPE_SQUARE, 17'h1FFFF, 2'd2, 1'b0);
      send_frame(24'h7FFFFF, 24'h800000);
      send_frame(24'h800000, 24'h7FFFFF);
      send_frame(rand_sample(), rand_sample());
      // shape code three, zero coefficient
      apply_settings(24'h012345, 17'd40000, SHAPE_SQUARE_ALT, 17'd0, 2'd2, 1'b0);
      send_frame(24'h7FFFFF, 24'h800000);
      send_frame(rand_sample(), rand_sample());
      // depth just below and at the bypass threshold
      apply_settings(24'h0, BYPASS_DEPTH - 17'd1, SHAPE_SINE, SMOOTH_COEFF_RESET, 2'd2, 1'b0);
      send_frame(24'h7FFFFF, 24'h800000);
      send_frame(rand_sample(), rand_sample());
      apply_settings(PHASE_STEP_RESET, BYPASS_DEPTH, SHAPE_SINE, SMOOTH_COEFF_RESET, 2'd2, 1'b0);
      send_frame(24'h7FFFFF, 24'h800000);
      // one channel, no channel, channel code three with a stray index write
      apply_settings(PHASE_STEP_RESET, ONE_Q16, SHAPE_TRIANGLE, SMOOTH_COEFF_RESET, 2'd1, 1'b0);
      send_frame(24'h7FFFFF, 24'h800000);
      send_frame(rand_sample(), rand_sample());
      apply_settings(PHASE_STEP_RESET, ONE_Q16, SHAPE_TRIANGLE, SMOOTH_COEFF_RESET, 2'd0, 1'b0);
      send_frame(24'h800000, 24'h7FFFFF);
      apply_settings(24'h3FFFFF, MOD_DEPTH_RESET, SHAPE_SINE, SMOOTH_COEFF_RESET, 2'd3, 1'b1);
      send_frame(24'h7FFFFF, 24'h800000);
      send_frame(rand_sample(), rand_sample());

      for (int mode = 0; mode < 3; mode++) begin
         case (mode)
            0: begin
               send_idle_pct = 28;
               recv_idle_pct = 50;
            end
            1: begin
               send_idle_pct = 50;
               recv_idle_pct = 28;
            end
            default: begin
               send_idle_pct = 0;
               recv_idle_pct = 0;
            end
         endcase
         for (int blk = 0; blk < BLOCKS_PER_MODE; blk++) begin
            apply_random_settings();
            repeat (FRAMES_PER_BLOCK) send_frame(rand_sample(), rand_sample());
         end
      end

      drain();
      $display("checked %0d frames over %0d register settings: sine, triangle, square shapes,",
               sb.frames_checked, settings_applied);
      $display("bypass, one and no channel, saturated depth and coefficient; %0d errors",
               sb.errors);
      if (sb.errors == 0 && sb.expected_frames.size() == 0) begin
         $display("** tremolo_lfo_gain_top: PASSED **");
      end else begin
         $display("** tremolo_lfo_gain_top: FAILED **");
      end
      $finish;
   end

endmodule
